[rtl/rmf_pkg.sv]
// Shared constants for the running median filter.
package rmf_pkg;

    localparam int OPCODE_BITS = 1;
    localparam int FILL_BITS   = 3;

    localparam logic [OPCODE_BITS-1:0] OP_PUSH  = 1'b0;
    localparam logic [OPCODE_BITS-1:0] OP_CLEAR = 1'b1;

endpackage

[rtl/rmf_in_if.sv]
// Input channel of the running median filter: opcode and sample.
interface rmf_in_if #(
    parameter int SAMPLE_BITS = 32
);
    logic                                  valid;
    logic                                  ready;
    logic [rmf_pkg::OPCODE_BITS-1:0]       opcode;
    logic signed [SAMPLE_BITS-1:0]         sample;

    modport source (output valid, output opcode, output sample, input ready);
    modport sink   (input valid, input opcode, input sample, output ready);
endinterface

[rtl/rmf_out_if.sv]
// Result channel of the running median filter: median and fill count.
interface rmf_out_if #(
    parameter int SAMPLE_BITS = 32
);
    logic                              valid;
    logic                              ready;
    logic signed [SAMPLE_BITS-1:0]     median;
    logic [rmf_pkg::FILL_BITS-1:0]     fill_count;

    modport source (output valid, output median, output fill_count, input ready);
    modport sink   (input valid, input median, input fill_count, output ready);
endinterface

[rtl/running_median_filter.sv]
// Running median filter: top level with window store and result register.
//
// Usage:
//   i_in  carries an opcode and a signed sample. A push (OP_PUSH) writes the
//         sample into the window, dropping the oldest once WINDOW are held,
//         and yields one result. A clear (OP_CLEAR) empties the window and
//         yields nothing.
//   o_out carries the median of the held samples (floored mean of the middle
//         pair when the count is even) and the fill count after the push.
// Timing:
//   One transaction per cycle sustained while o_out is ready. A push accepted
//   writes the window registers; the rank network reads them, and the result
//   register takes its output once o_out has room, so a stall can hold it.
//   The rank network (WINDOW x WINDOW compares, one pair add) is the path
//   between the window registers and the result register.
// Reset: empties the window and drops any pending or unsent result.
// Stall: a result waiting on o_out holds; one more push can be taken and
//   parked in the window, after which i_in.ready stays low until o_out moves.
module running_median_filter #(
    parameter int WINDOW      = 5,
    parameter int SAMPLE_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rmf_in_if.sink    i_in,
    rmf_out_if.source o_out
);

    localparam int CW = $clog2(WINDOW + 1);
    localparam int SW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    logic signed [SAMPLE_BITS-1:0] r_win [WINDOW];
    logic [CW-1:0]                 r_cnt;
    logic [SW-1:0]                 r_oldest;
    logic                          r_pend;
    logic [CW-1:0]                 r_pend_cnt;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_median;
    logic [rmf_pkg::FILL_BITS-1:0] r_out_fill;

    logic [CW-1:0]                 n_cnt;
    logic [SW-1:0]                 n_oldest;
    logic                          n_pend;
    logic [CW-1:0]                 wr_sel;
    logic                          full;
    logic                          advance;
    logic                          in_ready;
    logic                          accept;
    logic                          push;
    logic signed [SAMPLE_BITS-1:0] rank_median;
    logic [CW+rmf_pkg::FILL_BITS-1:0] fill_ext;

    assign full     = (r_cnt == CW'(WINDOW));
    assign advance  = r_pend && (!r_out_valid || o_out.ready);
    assign in_ready = !r_pend || advance;
    assign accept   = i_in.valid && in_ready;
    assign push     = accept && (i_in.opcode == rmf_pkg::OP_PUSH);

    // Below full the oldest slot is zero, so the next free slot is the count.
    assign wr_sel = full ? CW'(r_oldest) : r_cnt;

    always_comb begin
        n_cnt    = r_cnt;
        n_oldest = r_oldest;
        if (accept) begin
            if (i_in.opcode == rmf_pkg::OP_CLEAR) begin
                n_cnt    = '0;
                n_oldest = '0;
            end else if (full) begin
                n_oldest = (r_oldest == SW'(WINDOW - 1)) ? '0 : r_oldest + SW'(1);
            end else begin
                n_cnt = r_cnt + CW'(1);
            end
        end
    end

    always_comb begin
        n_pend = r_pend;
        if (push) begin
            n_pend = 1'b1;
        end else if (advance) begin
            n_pend = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_oldest <= '0;
            r_pend   <= 1'b0;
        end else begin
            r_cnt    <= n_cnt;
            r_oldest <= n_oldest;
            r_pend   <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < WINDOW; k++) begin
            if (push && (wr_sel == CW'(k))) begin
                r_win[k] <= i_in.sample;
            end
        end
        if (push) begin
            r_pend_cnt <= n_cnt;
        end
    end

    rmf_rank #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .CW          (CW)
    ) u_rank (
        .i_win    (r_win),
        .i_cnt    (r_pend_cnt),
        .o_median (rank_median)
    );

    assign fill_ext = {{rmf_pkg::FILL_BITS{1'b0}}, r_pend_cnt};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_median <= rank_median;
            r_out_fill   <= fill_ext[rmf_pkg::FILL_BITS-1:0];
        end
    end

    assign i_in.ready       = in_ready;
    assign o_out.valid      = r_out_valid;
    assign o_out.median     = r_out_median;
    assign o_out.fill_count = r_out_fill;

`ifndef SYNTHESIS
    // A clear never leaves a median pending.
    a_clear_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_in.opcode == rmf_pkg::OP_CLEAR)) |=> !r_pend)
        else $error("clear transaction left a pending result");

    // A push always queues a result carrying the updated count.
    a_push_pends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> (r_pend && (r_pend_cnt == r_cnt) && (r_cnt != '0)))
        else $error("push did not queue a result with the new count");

    // The window only rotates once it is full.
    a_rotate_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_oldest != '0) |-> (r_cnt == CW'(WINDOW)))
        else $error("oldest slot moved before the window filled");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(WINDOW))
        else $error("held count exceeds window size");
`endif

endmodule

[rtl/rmf_rank.sv]
// Rank network: picks the middle pair of the held samples and averages it.
module rmf_rank #(
    parameter int WINDOW      = 5,
    parameter int SAMPLE_BITS = 32,
    parameter int CW          = 3
) (
    input  logic signed [SAMPLE_BITS-1:0] i_win [WINDOW],
    input  logic        [CW-1:0]          i_cnt,
    output logic signed [SAMPLE_BITS-1:0] o_median
);

    logic [WINDOW-1:0]             below [WINDOW];
    logic [CW-1:0]                 rank  [WINDOW];
    logic [CW-1:0]                 lo_rank;
    logic [CW-1:0]                 hi_rank;
    logic [SAMPLE_BITS-1:0]        lo_val;
    logic [SAMPLE_BITS-1:0]        hi_val;
    logic signed [SAMPLE_BITS:0]   pair_sum;

    assign lo_rank = (i_cnt - CW'(1)) >> 1;
    assign hi_rank = i_cnt >> 1;

    // Rank of an entry = held entries smaller than it; ties broken by slot.
    always_comb begin
        for (int k = 0; k < WINDOW; k++) begin
            for (int j = 0; j < WINDOW; j++) begin
                below[k][j] = (CW'(j) < i_cnt) &&
                              ((i_win[j] < i_win[k]) ||
                               ((i_win[j] == i_win[k]) && (j < k)));
            end
            rank[k] = CW'($countones(below[k]));
        end
    end

    always_comb begin
        lo_val = '0;
        hi_val = '0;
        for (int k = 0; k < WINDOW; k++) begin
            if ((CW'(k) < i_cnt) && (rank[k] == lo_rank)) begin
                lo_val = lo_val | i_win[k];
            end
            if ((CW'(k) < i_cnt) && (rank[k] == hi_rank)) begin
                hi_val = hi_val | i_win[k];
            end
        end
    end

    // Odd count: both picks are the same entry, so the mean is exact.
    assign pair_sum = $signed({lo_val[SAMPLE_BITS-1], lo_val})
                    + $signed({hi_val[SAMPLE_BITS-1], hi_val});
    assign o_median = pair_sum[SAMPLE_BITS:1];

endmodule
